// File: hw/rtl/windowed_peak_centroid_top_macros.svh
`ifndef WINDOWED_PEAK_CENTROID_TOP_MACROS_SVH
`define WINDOWED_PEAK_CENTROID_TOP_MACROS_SVH
// assertion helpers
`define WPC_ASSERT_IMPL(lbl, clk, rst_n, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define WPC_ASSERT_NEXT(lbl, clk, rst_n, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

// File: hw/rtl/wpc_pkg.sv
`timescale 1ns / 1ps
package wpc_pkg;
	localparam int unsigned WS_RESET = 5;
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_LOW = 2'd1;
	localparam logic [1:0] ST_OFF = 2'd2;
	localparam logic [0:0] REQ_WRITE = 1'b0;
	localparam logic [0:0] REQ_QUERY = 1'b1;

	typedef struct packed {
		logic [0:0]  req_type;
		logic [6:0]  pos_x;
		logic [6:0]  pos_y;
		logic signed [15:0] pixel_value;
	} in_item_t;

	typedef struct packed {
		logic [14:0] centroid_x;
		logic [14:0] centroid_y;
		logic signed [23:0] total_intensity;
		logic [6:0]  peak_x;
		logic [6:0]  peak_y;
		logic [1:0]  status;
	} out_item_t;

	// controller -> datapath
	typedef struct packed {
		logic load;       // latch query, set up first window
		logic scan1;      // issue read of current pixel, first pass
		logic scan2;      // same, second pass
		logic acc1;       // consume read data, peak/min
		logic acc2;       // consume read data, moments
		logic adv;        // step window counters
		logic start2;     // set up second window
		logic div_start;  // start both divisions
		logic finish;     // form result
	} cmd_t;

	typedef struct packed {
		logic off1;
		logic off2;
		logic last;       // current position is the last of the window
		logic div_done;
		logic ok_sum;
	} sts_t;
endpackage

// File: hw/rtl/wpc_if.sv
`timescale 1ns / 1ps
interface wpc_in_if;
	logic valid;
	logic ready;
	wpc_pkg::in_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface wpc_out_if;
	logic valid;
	logic ready;
	wpc_pkg::out_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// File: hw/rtl/wpc_div.sv
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle, rounds half up, saturates
module wpc_div #(
	parameter int unsigned NW = 48
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,    // non-negative numerator (already *256 + den/2)
	input  logic [NW-1:0] den,
	output logic          done,
	output logic [14:0]   quo
);
	localparam int CW = $clog2(NW + 1);
	logic [NW-1:0] rem_q, quo_q, num_q, den_q;
	logic [CW-1:0] cnt_q;
	logic busy_q;
	logic [NW:0] trial;

	assign trial = {rem_q, num_q[NW-1]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CW'(NW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= '0;
			num_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			if (!trial[NW]) begin
				rem_q <= trial[NW-1:0];
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[NW-2:0], num_q[NW-1]};
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end
	end

	assign done = !busy_q && !start;
	assign quo = (quo_q > NW'(32767)) ? 15'h7fff : quo_q[14:0];
endmodule

// File: hw/rtl/wpc_datapath.sv
`timescale 1ns / 1ps
module wpc_datapath #(
	parameter int unsigned FRAME_WIDTH = 128,
	parameter int unsigned FRAME_HEIGHT = 128,
	parameter int unsigned MAX_WINDOW = 15
) (
	input  logic              clk,
	input  logic              arst_n,
	input  wpc_pkg::in_item_t in_item,
	input  logic              wr_en,
	input  logic [3:0]        window_size,
	input  wpc_pkg::cmd_t     cmd,
	output wpc_pkg::sts_t     sts,
	output wpc_pkg::out_item_t res
);
	localparam int XW = $clog2(FRAME_WIDTH);
	localparam int YW = $clog2(FRAME_HEIGHT);
	localparam int AW = XW + YW;
	localparam int DEPTH = 1 << AW;
	localparam int HW = $clog2(MAX_WINDOW + 1);
	localparam int CW = 12; // signed coordinate width, holds -MAX_WINDOW..1024+MAX_WINDOW
	localparam int SW = 28; // sum width: holds 225 * 2^15 (15 x 15 window)
	localparam int MW = SW + 11; // moment width
	localparam int NW = MW + 10;

	logic [15:0] mem [DEPTH];
	logic [15:0] rd_s1;

	// window half size
	logic [3:0] ws_sat;
	logic [HW-1:0] half;
	assign ws_sat = (32'(window_size) > MAX_WINDOW) ? 4'(MAX_WINDOW) : window_size;
	assign half = (ws_sat == 4'd0) ? '0 : HW'((ws_sat - 4'd1) >> 1);

	logic signed [CW-1:0] cx_q, cy_q, x_q, y_q, xe_q;
	logic [HW:0] ixc_q, iyc_q;
	logic signed [15:0] mx_q, mn_q;
	logic signed [CW-1:0] pkx_q, pky_q;
	logic signed [SW-1:0] sum_q;
	logic signed [MW-1:0] sx_q, sy_q;
	logic signed [18:0] th5_q;
	logic first_q;
	logic signed [CW-1:0] ex_s1, ey_s1;
	logic signed [CW-1:0] hs;
	assign hs = CW'(half);

	function automatic logic off(input logic signed [CW-1:0] cx, input logic signed [CW-1:0] cy,
		input logic signed [CW-1:0] h);
		off = (cx - h < 0) || (cy - h < 0) || (cx + h >= CW'(FRAME_WIDTH))
			|| (cy + h >= CW'(FRAME_HEIGHT));
	endfunction

	// writes outside the frame are dropped
	logic wr_ok;
	assign wr_ok = wr_en && (32'(in_item.pos_x) < FRAME_WIDTH)
		&& (32'(in_item.pos_y) < FRAME_HEIGHT);

	always_ff @(posedge clk) begin
		if (wr_ok) mem[{YW'(in_item.pos_y), XW'(in_item.pos_x)}] <= in_item.pixel_value;
		if (cmd.scan1 || cmd.scan2) rd_s1 <= mem[{y_q[YW-1:0], x_q[XW-1:0]}];
		if (cmd.scan1 || cmd.scan2) begin
			ex_s1 <= x_q;
			ey_s1 <= y_q;
		end
	end

	assign sts.off1 = off(cx_q, cy_q, hs);
	assign sts.off2 = off(pkx_q, pky_q, hs);
	assign sts.last = (ixc_q == {half, 1'b0}) && (iyc_q == {half, 1'b0});

	logic signed [15:0] v;
	logic signed [18:0] v5;
	logic signed [CW+16:0] mxp, myp;
	assign v = rd_s1;
	assign v5 = 19'(v) * 19'sd5;
	assign mxp = (CW+17)'(v) * (CW+17)'(ex_s1);
	assign myp = (CW+17)'(v) * (CW+17)'(ey_s1);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cx_q <= CW'({1'b0, in_item.pos_x});
			cy_q <= CW'({1'b0, in_item.pos_y});
			x_q <= CW'({1'b0, in_item.pos_x}) - hs;
			y_q <= CW'({1'b0, in_item.pos_y}) - hs;
			xe_q <= CW'({1'b0, in_item.pos_x}) - hs;
			ixc_q <= '0;
			iyc_q <= '0;
			first_q <= 1'b1;
			sum_q <= '0;
			sx_q <= '0;
			sy_q <= '0;
		end else if (cmd.start2) begin
			x_q <= pkx_q - hs;
			y_q <= pky_q - hs;
			xe_q <= pkx_q - hs;
			ixc_q <= '0;
			iyc_q <= '0;
			th5_q <= 19'(mx_q) + (19'(mn_q) <<< 2);
		end else if (cmd.adv) begin
			if (ixc_q == {half, 1'b0}) begin
				ixc_q <= '0;
				iyc_q <= iyc_q + 1'b1;
				x_q <= xe_q;
				y_q <= y_q + CW'(1);
			end else begin
				ixc_q <= ixc_q + 1'b1;
				x_q <= x_q + CW'(1);
			end
		end
		if (cmd.acc1) begin
			first_q <= 1'b0;
			if (first_q || v > mx_q) begin
				mx_q <= v;
				pkx_q <= ex_s1;
				pky_q <= ey_s1;
			end
			if (first_q || v < mn_q) mn_q <= v;
		end
		if (cmd.acc2 && (v5 > th5_q)) begin
			sum_q <= sum_q + SW'(v);
			sx_q <= sx_q + MW'(mxp);
			sy_q <= sy_q + MW'(myp);
		end
	end

	// divisions
	logic signed [SW+3:0] sum5;
	assign sum5 = (SW+4)'(sum_q) * (SW+4)'(5);
	assign sts.ok_sum = (sum5 > (SW+4)'(th5_q)) && (sum_q > 0);
	logic [NW-1:0] den, numx, numy;
	logic signed [NW-1:0] nx, ny;
	assign den = NW'(sum_q);
	assign nx = NW'(sx_q) <<< 8;
	assign ny = NW'(sy_q) <<< 8;
	assign numx = (nx > 0) ? NW'(nx + NW'(sum_q >>> 1)) : '0;
	assign numy = (ny > 0) ? NW'(ny + NW'(sum_q >>> 1)) : '0;
	logic dxd, dyd;
	logic [14:0] qx, qy;
	wpc_div #(.NW(NW)) u_divx (.clk, .arst_n, .start(cmd.div_start), .num(numx), .den(den),
		.done(dxd), .quo(qx));
	wpc_div #(.NW(NW)) u_divy (.clk, .arst_n, .start(cmd.div_start), .num(numy), .den(den),
		.done(dyd), .quo(qy));
	assign sts.div_done = dxd && dyd;

	logic signed [23:0] tot;
	assign tot = (sum_q > SW'(8388607)) ? 24'sh7fffff :
		(sum_q < -SW'(8388608)) ? 24'sh800000 : 24'(sum_q);

	wpc_pkg::out_item_t res_d;
	always_comb begin
		res_d = '0;
		res_d.status = wpc_pkg::ST_OFF;
		if (!sts.off1) begin
			res_d.peak_x = pkx_q[6:0];
			res_d.peak_y = pky_q[6:0];
			if (!sts.off2) begin
				res_d.total_intensity = tot;
				if (sts.ok_sum) begin
					res_d.status = wpc_pkg::ST_OK;
					res_d.centroid_x = qx;
					res_d.centroid_y = qy;
				end else begin
					res_d.status = wpc_pkg::ST_LOW;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) res <= res_d;
	end
endmodule

// File: hw/rtl/wpc_ctrl.sv
`timescale 1ns / 1ps
module wpc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_query,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  wpc_pkg::sts_t sts,
	output wpc_pkg::cmd_t cmd
);
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_CHK1 = 4'd1;
	localparam logic [3:0] S_RD1  = 4'd2;
	localparam logic [3:0] S_AC1  = 4'd3;
	localparam logic [3:0] S_CHK2 = 4'd4;
	localparam logic [3:0] S_RD2  = 4'd5;
	localparam logic [3:0] S_AC2  = 4'd6;
	localparam logic [3:0] S_DIV  = 4'd7;
	localparam logic [3:0] S_WAIT = 4'd8;
	localparam logic [3:0] S_FIN  = 4'd9;
	localparam logic [3:0] S_OUT  = 4'd10;

	logic [3:0] state_q, state_d;
	logic last_q;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid && in_query) begin
					cmd.load = 1'b1;
					state_d = S_CHK1;
				end
			end
			S_CHK1: state_d = sts.off1 ? S_FIN : S_RD1;
			S_RD1: begin
				cmd.scan1 = 1'b1;
				cmd.adv = 1'b1;
				state_d = S_AC1;
			end
			S_AC1: begin
				cmd.acc1 = 1'b1;
				state_d = last_q ? S_CHK2 : S_RD1;
			end
			S_CHK2: begin
				cmd.start2 = 1'b1;
				state_d = sts.off2 ? S_FIN : S_RD2;
			end
			S_RD2: begin
				cmd.scan2 = 1'b1;
				cmd.adv = 1'b1;
				state_d = S_AC2;
			end
			S_AC2: begin
				cmd.acc2 = 1'b1;
				state_d = last_q ? S_DIV : S_RD2;
			end
			S_DIV: begin
				cmd.div_start = 1'b1;
				state_d = S_WAIT;
			end
			S_WAIT: if (sts.div_done) state_d = S_FIN;
			S_FIN: begin
				cmd.finish = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: if (out_ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			last_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.scan1 || cmd.scan2) last_q <= sts.last;
		end
	end
endmodule

// File: hw/rtl/windowed_peak_centroid_top.sv
`timescale 1ns / 1ps
// Windowed peak centroid. A pixel write (req_type 0) is taken while idle and
// gives no result. A query scans the search window (side n = window_size,
// odd sides used as is) reading one pixel at a time from the single port
// frame store, then the same-size window around the peak, then runs two
// bit-serial dividers in parallel; a window off the frame ends the query early.
// One item at a time; the result is held until taken.
module windowed_peak_centroid_top #(
	parameter int unsigned FRAME_WIDTH = 128,
	parameter int unsigned FRAME_HEIGHT = 128,
	parameter int unsigned MAX_WINDOW = 15
) (
	input  logic        clk,
	input  logic        arst_n,
	wpc_in_if.sink      in_ch,
	wpc_out_if.source   out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	logic [3:0] window_size_q;
	wpc_pkg::cmd_t cmd;
	wpc_pkg::sts_t sts;
	logic in_ready;

	assign pready = 1'b1;
	assign prdata = (paddr == 2'd0) ? {28'd0, window_size_q} : 32'd0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) window_size_q <= 4'(wpc_pkg::WS_RESET);
		else if (psel && penable && pwrite && paddr == 2'd0) window_size_q <= pwdata[3:0];
	end

	assign in_ch.ready = in_ready;

	wpc_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(in_ch.valid),
		.in_query(in_ch.data.req_type == wpc_pkg::REQ_QUERY),
		.in_ready,
		.out_valid(out_ch.valid),
		.out_ready(out_ch.ready),
		.sts, .cmd
	);

	wpc_datapath #(.FRAME_WIDTH(FRAME_WIDTH), .FRAME_HEIGHT(FRAME_HEIGHT),
		.MAX_WINDOW(MAX_WINDOW)) u_dp (
		.clk, .arst_n,
		.in_item(in_ch.data),
		.wr_en(in_ch.valid && in_ready && in_ch.data.req_type == wpc_pkg::REQ_WRITE),
		.window_size(window_size_q),
		.cmd, .sts,
		.res(out_ch.data)
	);
endmodule

// File: hw/rtl/wpc_checker.sv
`timescale 1ns / 1ps
`include "windowed_peak_centroid_top_macros.svh"
module wpc_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [1:0] status,
	input logic [14:0] centroid_x
);
	logic fail_res;
	assign fail_res = out_valid && (status != wpc_pkg::ST_OK);

	`WPC_ASSERT_IMPL(a_no_in_while_out, clk, arst_n, out_valid, !(in_valid && in_ready), "input taken during result")
	`WPC_ASSERT_IMPL(a_status_code, clk, arst_n, out_valid, status <= wpc_pkg::ST_OFF, "bad status")
	`WPC_ASSERT_IMPL(a_cx_zero, clk, arst_n, fail_res, centroid_x == '0, "centroid on fail")
	`WPC_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result dropped")
endmodule

bind windowed_peak_centroid_top wpc_checker u_chk (
	.clk, .arst_n,
	.in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.status(out_ch.data.status), .centroid_x(out_ch.data.centroid_x)
);
